// ===== hw/rtl/lsbu_pkg.sv =====
// Shared types and constants for the LCD spectrum bar updater.
`default_nettype none

package lsbu_pkg;

  localparam int unsigned MaxColumnDef = 39;
  localparam int unsigned CellDepth    = 4;

  localparam logic [6:0] I2cAddrReset   = 7'h27;
  localparam logic       BacklightReset = 1'b1;

  localparam logic [7:0] CmdDdram  = 8'h80;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] GlyphFull = 8'h07;
  localparam logic [4:0] LevelTopFirst = 5'd9;
  localparam logic [4:0] LevelMax      = 5'd16;

  typedef enum logic {
    CfgI2cAddr   = 1'b0,
    CfgBacklight = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0] bar_level;
    logic [4:0] previous_level;
    logic [5:0] column;
  } in_item_t;

  typedef struct packed {
    logic [6:0] bus_address;
    logic [7:0] expander_byte;
    logic       last_of_run;
  } out_item_t;

  // One display cell: cursor command byte, character byte, end-of-run mark
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] ch;
    logic       last;
  } cell_t;

  typedef struct packed {
    logic [1:0] cnt;
    cell_t      c0;
    cell_t      c1;
  } cell_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lsbu_front.sv =====
// Front end: classifies an update into zero, one or two display cells.
`default_nettype none

module lsbu_front import lsbu_pkg::*; #(
  parameter int unsigned MaxColumn = MaxColumnDef
) (
  input  logic     accept_i,
  input  in_item_t item_i,
  output cell_wr_t wr_o
);

  logic [5:0] col;
  logic [4:0] lvl;
  logic [4:0] old;
  logic       main_vld;
  logic       main_bot;
  logic [7:0] main_ch;
  logic       fix_vld;
  logic       fix_bot;
  logic [7:0] fix_ch;
  cell_t      main_cell;
  cell_t      fix_cell;

  assign lvl = item_i.bar_level;
  assign old = item_i.previous_level;
  assign col = (item_i.column > 6'(MaxColumn)) ? 6'(MaxColumn) : item_i.column;

  always_comb begin
    main_vld = (lvl <= LevelMax);
    main_bot = (lvl < LevelTopFirst);
    if (lvl == 5'd0) begin
      main_ch = CharSpace;
    end else if (main_bot) begin
      main_ch = {3'b000, lvl - 5'd1};
    end else begin
      main_ch = {3'b000, lvl - LevelTopFirst};
    end

    // Clear a stale top cell, or fill the bottom cell under a new top cell
    fix_vld = 1'b0;
    fix_bot = 1'b0;
    fix_ch  = CharSpace;
    if (lvl < LevelTopFirst && old >= LevelTopFirst) begin
      fix_vld = 1'b1;
    end else if (lvl >= LevelTopFirst && old < 5'd8) begin
      fix_vld = 1'b1;
      fix_bot = 1'b1;
      fix_ch  = GlyphFull;
    end
  end

  assign main_cell = '{addr: {CmdDdram[7], main_bot, col}, ch: main_ch, last: !fix_vld};
  assign fix_cell  = '{addr: {CmdDdram[7], fix_bot, col}, ch: fix_ch, last: 1'b1};

  always_comb begin
    wr_o.cnt = 2'd0;
    wr_o.c0  = main_cell;
    wr_o.c1  = fix_cell;
    if (accept_i) begin
      if (main_vld) begin
        wr_o.cnt = fix_vld ? 2'd2 : 2'd1;
      end else if (fix_vld) begin
        wr_o.cnt = 2'd1;
        wr_o.c0  = fix_cell;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lsbu_cell_fifo.sv =====
// Short queue of display cells between front end and serializer.
`default_nettype none

module lsbu_cell_fifo import lsbu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cell_wr_t wr_i,
  input  logic     rd_i,
  output cell_t    head_o,
  output logic     empty_o,
  output logic     full_o
);

  localparam int unsigned AddrW = $clog2(CellDepth);
  localparam int unsigned CntW  = $clog2(CellDepth + 1);

  cell_t            mem_q [CellDepth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] wr_ptr_nxt;

  assign wr_ptr_nxt = wr_ptr_q + AddrW'(1);
  assign head_o     = mem_q[rd_ptr_q];
  assign empty_o    = (cnt_q == '0);
  // Keep room for a full two-cell update
  assign full_o     = (cnt_q > CntW'(CellDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + AddrW'(wr_i.cnt);
    rd_ptr_d = rd_ptr_q + AddrW'(rd_i);
    cnt_d    = cnt_q + CntW'(wr_i.cnt) - CntW'(rd_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_i.c0;
    end
    if (wr_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nxt] <= wr_i.c1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lsbu_back.sv =====
// Back end: turns each cell into eight expander bytes, one per cycle unless the receiver stalls.
`default_nettype none

module lsbu_back import lsbu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_t      head_i,
  input  logic       head_empty_i,
  output logic       head_rd_o,
  input  logic [6:0] i2c_addr_i,
  input  logic       backlight_i,
  output out_item_t  out_o,
  output logic       out_vld_o,
  input  logic       out_rd_i
);

  logic [2:0] step_q, step_d;
  logic       vld_q, vld_d;
  out_item_t  out_q;
  logic       adv;
  logic [7:0] sel_byte;
  logic [3:0] nib;
  logic       rs;
  out_item_t  beat;

  // step[2]: command/char, step[1]: high/low nibble, step[0]: EN set/clear
  assign adv      = !head_empty_i && (!vld_q || out_rd_i);
  assign rs       = step_q[2];
  assign sel_byte = rs ? head_i.ch : head_i.addr;
  assign nib      = step_q[1] ? sel_byte[3:0] : sel_byte[7:4];
  assign head_rd_o = adv && (step_q == 3'd7);

  always_comb begin
    beat.bus_address   = i2c_addr_i;
    beat.expander_byte = {nib, backlight_i, !step_q[0], 1'b0, rs};
    beat.last_of_run   = head_i.last && (step_q == 3'd7);
    step_d = adv ? step_q + 3'd1 : step_q;
    vld_d  = adv ? 1'b1 : (vld_q && !out_rd_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      vld_q  <= vld_d;
    end
  end

  assign out_o     = out_q;
  assign out_vld_o = vld_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lcd_spectrum_bar_updater.sv =====
// Bar-graph column updater for a 2-row character LCD behind an I2C expander.
//
// Input channel: push/full with in_item_i (bar level, previous level, column).
// Each update becomes zero, one or two display cells (cursor command plus one
// character); each cell leaves as eight expander bytes on the result channel
// (empty/pop, out_item_o), the last byte of an update marked by last_of_run.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0: I2C bus address, 1: backlight enable) at the clock edge.
// An accepted update is written into the cell queue; its first byte is then
// shown from the serializer's output register, ready to be popped.
// Throughput: one expander byte per cycle while the receiver pops, set by the
// byte serializer; updates with nothing to draw produce no bytes.
// A four-cell queue sits between classifier and serializer; full rises while
// fewer than two cells are free, so push may continue while results wait.
// When the receiver stalls, the current byte holds and the queue fills.
// Reset empties the queue and output, sets the address to 0x27 and the
// backlight on.
`default_nettype none

module lcd_spectrum_bar_updater import lsbu_pkg::*; #(
  parameter int unsigned MaxColumn = MaxColumnDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_item_i,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_item_o,
  input  logic       cfg_we_i,
  input  cfg_idx_e   cfg_idx_i,
  input  logic [6:0] cfg_wdata_i
);

  logic [6:0] i2c_addr_q;
  logic       backlight_q;
  cell_wr_t   cell_wr;
  cell_t      head;
  logic       head_empty;
  logic       head_rd;
  logic       out_vld;
  logic       accept;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i2c_addr_q  <= I2cAddrReset;
      backlight_q <= BacklightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgI2cAddr:   i2c_addr_q  <= cfg_wdata_i;
        CfgBacklight: backlight_q <= cfg_wdata_i[0];
        default:      ;
      endcase
    end
  end

  lsbu_front #(
    .MaxColumn(MaxColumn)
  ) u_front (
    .accept_i (accept),
    .item_i   (in_item_i),
    .wr_o     (cell_wr)
  );

  lsbu_cell_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cell_wr),
    .rd_i    (head_rd),
    .head_o  (head),
    .empty_o (head_empty),
    .full_o  (full)
  );

  lsbu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (head_empty),
    .head_rd_o    (head_rd),
    .i2c_addr_i   (i2c_addr_q),
    .backlight_i  (backlight_q),
    .out_o        (out_item_o),
    .out_vld_o    (out_vld),
    .out_rd_i     (pop)
  );

  assign empty = !out_vld;

endmodule

`default_nettype wire

// ===== hw/rtl/lsbu_checker.sv =====
// Port-level checks for the bar updater, bound to the top level.
`default_nettype none

module lsbu_checker import lsbu_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  // Stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("result beat changed while stalled");

  // An EN-set beat is followed at once by the same nibble with EN clear
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && out_item_o.expander_byte[2] |=>
      !empty && !out_item_o.expander_byte[2]
      && out_item_o.expander_byte[7:3] == $past(out_item_o.expander_byte[7:3])
      && out_item_o.expander_byte[0] == $past(out_item_o.expander_byte[0]))
    else $error("EN strobe not followed by matching EN-clear beat");

  // Run ends on a data beat with EN clear
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.last_of_run |->
      !out_item_o.expander_byte[2] && out_item_o.expander_byte[0])
    else $error("end of run on wrong beat");

  a_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !out_item_o.expander_byte[1])
    else $error("read bit set in expander byte");

endmodule

bind lcd_spectrum_bar_updater lsbu_checker u_lsbu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

`default_nettype wire

// ===== tb/lcd_bar_checker.sv =====
// Checker for the LCD bar updater: predicts the expander beats of each update and compares them.
module lcd_bar_checker import lsbu_pkg::*; #(
  parameter int unsigned MaxColumn = MaxColumnDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  in_item_t    in_item_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  out_item_t   out_item_i,
  input  logic        cfg_we_i,
  input  cfg_idx_e    cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  localparam logic [7:0] RowBottom = 8'h40;

  logic [6:0]  bus_addr_q;
  logic        backlight_q;
  out_item_t   beats_due_q[$];
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("%0t mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // One nibble leaves as two beats: EN high, then EN low
  function automatic void queue_nibble(logic [3:0] nib, logic rs, logic last);
    out_item_t beat;
    beat.bus_address   = bus_addr_q;
    beat.expander_byte = {nib, backlight_q, 1'b1, 1'b0, rs};
    beat.last_of_run   = 1'b0;
    beats_due_q.push_back(beat);
    beat.expander_byte = {nib, backlight_q, 1'b0, 1'b0, rs};
    beat.last_of_run   = last;
    beats_due_q.push_back(beat);
  endfunction

  function automatic void queue_display_byte(logic [7:0] value, logic rs, logic last);
    queue_nibble(value[7:4], rs, 1'b0);
    queue_nibble(value[3:0], rs, last);
  endfunction

  function automatic void predict_redraw(in_item_t upd);
    logic [7:0] col;
    logic [7:0] cmd [2];
    logic [7:0] chr [2];
    int         n;
    col = (upd.column > MaxColumn) ? 8'(MaxColumn) : {2'b00, upd.column};
    n = 0;
    if (upd.bar_level <= LevelMax) begin
      if (upd.bar_level < LevelTopFirst) begin
        cmd[0] = CmdDdram | (col + RowBottom);
        chr[0] = (upd.bar_level == '0) ? CharSpace : 8'(upd.bar_level - 1);
      end else begin
        cmd[0] = CmdDdram | col;
        chr[0] = 8'(upd.bar_level - LevelTopFirst);
      end
      n = 1;
    end
    // Clear the top cell on a drop, fill the bottom cell on a rise from below full
    if (upd.bar_level < LevelTopFirst && upd.previous_level >= LevelTopFirst) begin
      cmd[n] = CmdDdram | col;
      chr[n] = CharSpace;
      n++;
    end else if (upd.bar_level >= LevelTopFirst && upd.previous_level < LevelTopFirst - 1) begin
      cmd[n] = CmdDdram | (col + RowBottom);
      chr[n] = GlyphFull;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      queue_display_byte(cmd[i], 1'b0, 1'b0);
      queue_display_byte(chr[i], 1'b1, i == n - 1);
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      bus_addr_q  = I2cAddrReset;
      backlight_q = BacklightReset;
      beats_due_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgI2cAddr:   bus_addr_q  = cfg_wdata_i;
          CfgBacklight: backlight_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        if (beats_due_q.size() == 0) begin
          report_mismatch("beat with nothing due", out_item_i, 0);
        end else begin
          want = beats_due_q.pop_front();
          if (out_item_i.bus_address !== want.bus_address)
            report_mismatch("bus_address", out_item_i.bus_address, want.bus_address);
          if (out_item_i.expander_byte !== want.expander_byte)
            report_mismatch("expander_byte", out_item_i.expander_byte, want.expander_byte);
          if (out_item_i.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", out_item_i.last_of_run, want.last_of_run);
        end
      end
      if (push_i && !full_i) predict_redraw(in_item_i);
    end
    pending_o = beats_due_q.size();
  end

endmodule

// ===== tb/tb_lcd_spectrum_bar_updater.sv =====
// Testbench top for the LCD bar updater: drives updates, settings and pops, gives the verdict.
module tb_lcd_spectrum_bar_updater;
  import lsbu_pkg::*;

  typedef enum int unsigned {PaceSteady, PaceJitter, PaceBursty} pace_e;

  localparam int unsigned PhaseCount      = 5;
  localparam int unsigned UpdatesPerPhase = 60;
  localparam int unsigned SettleCycles    = 6;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic        empty;
  logic        pop;
  in_item_t    in_item;
  out_item_t   out_item;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [6:0]  cfg_wdata;
  int unsigned pending;
  int unsigned fail_count;
  pace_e       tx_pace;
  int unsigned tx_left;
  logic [4:0]  shown_level [40];

  // Fields: bar_level, previous_level, column
  in_item_t edge_cases [20] = '{
    {5'd0,  5'd0,  6'd0},  {5'd0,  5'd9,  6'd1},  {5'd1,  5'd0,  6'd2},
    {5'd8,  5'd7,  6'd3},  {5'd8,  5'd8,  6'd4},  {5'd8,  5'd16, 6'd5},
    {5'd9,  5'd0,  6'd6},  {5'd9,  5'd7,  6'd7},  {5'd9,  5'd8,  6'd8},
    {5'd16, 5'd9,  6'd9},  {5'd16, 5'd31, 6'd39}, {5'd12, 5'd3,  6'd40},
    {5'd5,  5'd20, 6'd63}, {5'd17, 5'd0,  6'd10}, {5'd17, 5'd8,  6'd11},
    {5'd31, 5'd31, 6'd12}, {5'd31, 5'd7,  6'd13}, {5'd0,  5'd31, 6'd14},
    {5'd16, 5'd0,  6'd62}, {5'd3,  5'd3,  6'd38}
  };

  lcd_spectrum_bar_updater uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  lcd_bar_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push_i      (push),
    .full_i      (full),
    .in_item_i   (in_item),
    .empty_i     (empty),
    .pop_i       (pop),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_wait(pace_e pace);
    case (pace)
      PaceSteady: return 0;
      PaceJitter: return $urandom_range(0, 16);
      default:    return ($urandom_range(0, 7) == 0) ? 16 : 0;
    endcase
  endfunction

  // Mostly redraw a column from its current height; the rest is noise
  function automatic in_item_t random_update();
    in_item_t    upd;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      upd.column         = 6'($urandom_range(0, MaxColumnDef));
      upd.previous_level = shown_level[upd.column];
      upd.bar_level      = 5'($urandom_range(0, LevelMax));
    end else if (pick < 9) begin
      upd.column         = 6'($urandom_range(0, 63));
      upd.previous_level = 5'($urandom_range(0, 31));
      upd.bar_level      = 5'($urandom_range(0, LevelMax));
    end else begin
      upd = 16'($urandom);
    end
    return upd;
  endfunction

  task automatic send_update(in_item_t upd);
    int unsigned gap;
    if (tx_left == 0) begin
      tx_pace = pace_e'($urandom_range(0, 2));
      tx_left = $urandom_range(8, 40);
    end
    tx_left--;
    gap = pick_wait(tx_pace);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= upd;
    do @(posedge clk); while (full);
    if (upd.bar_level <= LevelMax)
      shown_level[(upd.column > MaxColumnDef) ? MaxColumnDef : upd.column] = upd.bar_level;
  endtask

  // Hold off the sender until every due beat has left, then let the pipe settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apply_settings(logic [6:0] addr, logic backlight);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgI2cAddr;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_idx   <= CfgBacklight;
    cfg_wdata <= {6'b0, backlight};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    push      = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CfgI2cAddr;
    cfg_wdata = '0;
    tx_pace   = PaceSteady;
    tx_left   = 0;
    foreach (shown_level[i]) shown_level[i] = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (edge_cases[i]) send_update(edge_cases[i]);
    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      case (p)
        0:       apply_settings(7'h00, 1'b0);
        1:       apply_settings(7'h7f, 1'b1);
        default: apply_settings(7'($urandom), 1'($urandom));
      endcase
      repeat (UpdatesPerPhase) send_update(random_update());
    end
    drain();
    if (fail_count == 0) begin
      $display("lcd_spectrum_bar_updater test passed");
    end else begin
      $display("lcd_spectrum_bar_updater test failed");
    end
    $finish;
  end

  // Result side: pop with random stalls, paced in stretches
  initial begin
    int unsigned stall;
    pace_e       rx_pace;
    int unsigned rx_left;
    pop     = 1'b0;
    rx_pace = PaceSteady;
    rx_left = 0;
    forever begin
      if (rx_left == 0) begin
        rx_pace = pace_e'($urandom_range(0, 2));
        rx_left = $urandom_range(8, 48);
      end
      rx_left--;
      stall = pick_wait(rx_pace);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin
    #5_000_000;
    $display("lcd_spectrum_bar_updater test failed");
    $finish;
  end

endmodule
